### design/euclidean_mst_total_length_defines.svh
// Assertion helpers used by the controller.
`ifndef EUCLIDEAN_MST_TOTAL_LENGTH_DEFINES_SVH
`define EUCLIDEAN_MST_TOTAL_LENGTH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/emst_pkg.sv
package emst_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int RT_W    = DIFF_W;
  localparam int SQ_W    = 2 * RT_W;
  localparam int TOT_W   = 32;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef struct packed {
    logic load_wr;
    logic load_pick0;
    logic init;
    logic issue;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic sqrt_busy;
    logic sqrt_done;
  } sts_t;

endpackage

### design/emst_isqrt.sv
module emst_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [emst_pkg::SQ_W-1:0]  operand,
  output logic                       busy,
  output logic                       done,
  output logic [emst_pkg::RT_W-1:0]  root
);
  import emst_pkg::*;

  localparam int REM_W = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [SQ_W-1:0]   op;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic              ge;

  // One result bit per cycle, restoring method.
  assign rem_t = {rem, op[SQ_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op   <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        op <= {op[SQ_W-3:0], 2'b00};
        if (ge) begin
          rem  <= REM_W'(rem_t - trial);
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(rem_t);
          root <= {root[RT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/emst_dp.sv
module emst_dp #(
  parameter int MAX_POINTS = emst_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  emst_pkg::cmd_t                      cmd,
  input  logic [AW-1:0]                       idx,
  input  logic [AW-1:0]                       widx,
  input  logic signed [emst_pkg::COORD_W-1:0] x_coord,
  input  logic signed [emst_pkg::COORD_W-1:0] y_coord,
  output emst_pkg::sts_t                      sts,
  output logic [emst_pkg::TOT_W-1:0]          total_length
);
  import emst_pkg::*;

  logic signed [COORD_W-1:0] xmem [MAX_POINTS];
  logic signed [COORD_W-1:0] ymem [MAX_POINTS];
  logic [SQ_W-1:0]           dmem [MAX_POINTS];

  logic [MAX_POINTS-1:0]     tree_in;
  logic                      first;
  logic signed [COORD_W-1:0] pick_x, pick_y;

  // Stage 1: memory read data.
  logic                      s1_v, s1_in;
  logic [AW-1:0]             s1_idx;
  logic signed [COORD_W-1:0] s1_x, s1_y;
  logic [SQ_W-1:0]           s1_d;
  // Stage 2: absolute differences.
  logic                      s2_v, s2_in;
  logic [AW-1:0]             s2_idx;
  logic signed [COORD_W-1:0] s2_x, s2_y;
  logic [SQ_W-1:0]           s2_d;
  logic [DIFF_W-1:0]         s2_ax, s2_ay;
  // Stage 3: squares.
  logic                      s3_v, s3_in;
  logic [AW-1:0]             s3_idx;
  logic signed [COORD_W-1:0] s3_x, s3_y;
  logic [SQ_W-1:0]           s3_d, s3_sx, s3_sy;
  // Stage 4: squared distance.
  logic                      s4_v, s4_in;
  logic [AW-1:0]             s4_idx;
  logic signed [COORD_W-1:0] s4_x, s4_y;
  logic [SQ_W-1:0]           s4_d, s4_sq;
  // Stage 5: relaxed distance.
  logic                      s5_v, s5_in;
  logic [AW-1:0]             s5_idx;
  logic signed [COORD_W-1:0] s5_x, s5_y;
  logic [SQ_W-1:0]           s5_nd;

  logic                      found;
  logic [SQ_W-1:0]           best;
  logic [AW-1:0]             best_idx;
  logic signed [COORD_W-1:0] best_x, best_y;

  logic signed [DIFF_W-1:0]  dx, dy;
  logic                      sq_busy, sq_done;
  logic [RT_W-1:0]           sq_root;
  logic [TOT_W-1:0]          total;
  logic [TOT_W:0]            sum;

  assign dx  = DIFF_W'(s1_x) - DIFF_W'(pick_x);
  assign dy  = DIFF_W'(s1_y) - DIFF_W'(pick_y);
  assign sum = {1'b0, total} + (TOT_W + 1)'(sq_root);

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      xmem[widx] <= x_coord;
      ymem[widx] <= y_coord;
    end
    s1_x <= xmem[idx];
    s1_y <= ymem[idx];
    s1_d <= dmem[idx];
    if (s5_v && !s5_in) begin
      dmem[s5_idx] <= s5_nd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      found <= 1'b0;
      first <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      if (cmd.init || cmd.commit) begin
        found <= 1'b0;
        first <= cmd.init;
      end else if (s5_v && !s5_in && (!found || s5_nd < best)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= idx;
    s1_in  <= tree_in[idx];

    s2_idx <= s1_idx;
    s2_in  <= s1_in;
    s2_x   <= s1_x;
    s2_y   <= s1_y;
    s2_d   <= s1_d;
    s2_ax  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    s2_ay  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    s3_idx <= s2_idx;
    s3_in  <= s2_in;
    s3_x   <= s2_x;
    s3_y   <= s2_y;
    s3_d   <= s2_d;
    s3_sx  <= s2_ax * s2_ax;
    s3_sy  <= s2_ay * s2_ay;

    s4_idx <= s3_idx;
    s4_in  <= s3_in;
    s4_x   <= s3_x;
    s4_y   <= s3_y;
    s4_d   <= s3_d;
    s4_sq  <= s3_sx + s3_sy;

    s5_idx <= s4_idx;
    s5_in  <= s4_in;
    s5_x   <= s4_x;
    s5_y   <= s4_y;
    s5_nd  <= (first || s4_sq < s4_d) ? s4_sq : s4_d;

    if (s5_v && !s5_in && (!found || s5_nd < best)) begin
      best     <= s5_nd;
      best_idx <= s5_idx;
      best_x   <= s5_x;
      best_y   <= s5_y;
    end

    if (cmd.load_pick0) begin
      pick_x <= x_coord;
      pick_y <= y_coord;
    end else if (cmd.commit) begin
      pick_x <= best_x;
      pick_y <= best_y;
    end

    if (cmd.init) begin
      total <= '0;
    end else if (sq_done) begin
      total <= sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
    end

    if (cmd.out_load) begin
      total_length <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_in <= '0;
    end else if (cmd.init) begin
      tree_in <= MAX_POINTS'(1);
    end else if (cmd.commit) begin
      tree_in[best_idx] <= 1'b1;
    end
  end

  emst_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.commit),
    .operand (best),
    .busy    (sq_busy),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign sts.pipe_busy = s1_v | s2_v | s3_v | s4_v | s5_v;
  assign sts.sqrt_busy = sq_busy;
  assign sts.sqrt_done = sq_done;

endmodule

### design/emst_ctrl.sv
`include "euclidean_mst_total_length_defines.svh"

module emst_ctrl #(
  parameter int MAX_POINTS = emst_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           is_last,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           overflowed,
  output emst_pkg::cmd_t cmd,
  input  emst_pkg::sts_t sts,
  output logic [AW-1:0]  idx,
  output logic [AW-1:0]  widx
);
  import emst_pkg::*;

  localparam int CW = AW + 1;

  typedef enum logic [2:0] {IDLE, SWEEP, DRAIN, COMMIT, FINISH, DONE} state_t;

  state_t        state;
  logic [CW-1:0] count, n, k, sweep, nsum;
  logic          drop, ovf_pend, accept, room;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid & in_ready;
  assign room     = count < CW'(MAX_POINTS);
  assign nsum     = count + CW'(room);
  assign widx     = count[AW-1:0];
  assign idx      = sweep[AW-1:0];

  always_comb begin
    cmd            = '0;
    cmd.load_wr    = accept & room;
    cmd.load_pick0 = accept & room & (count == '0);
    cmd.init       = accept & is_last;
    cmd.issue      = (state == SWEEP);
    cmd.commit     = (state == COMMIT) & !sts.sqrt_busy;
    cmd.out_load   = (state == DONE) & (!out_valid | out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid  <= 1'b1;
        overflowed <= ovf_pend;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (is_last) begin
              n        <= nsum;
              ovf_pend <= drop | !room;
              count    <= '0;
              drop     <= 1'b0;
              k        <= CW'(1);
              sweep    <= '0;
              state    <= (nsum < CW'(2)) ? DONE : SWEEP;
            end else if (room) begin
              count <= count + 1'b1;
            end else begin
              drop <= 1'b1;
            end
          end
        end
        SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == n - 1'b1) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!sts.pipe_busy) begin
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (!sts.sqrt_busy) begin
            k     <= k + 1'b1;
            sweep <= '0;
            state <= (k == n - 1'b1) ? FINISH : SWEEP;
          end
        end
        FINISH: begin
          if (!sts.sqrt_busy && !sts.sqrt_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `EMST_ASSERT_NOW(a_sweep_in_range, state == SWEEP, sweep < n, "sweep index past point count")
  `EMST_ASSERT_NOW(a_commit_drained, cmd.commit, !sts.pipe_busy, "commit while pipeline busy")
  `EMST_ASSERT_NEXT(a_done_idle, state == DONE, !sts.sqrt_busy && !sts.pipe_busy,
    "result taken while datapath busy")

endmodule

### design/euclidean_mst_total_length.sv
// Euclidean minimum spanning tree total length.
// Input channel (in_valid/in_ready): one transaction carries one point, x_coord and
// y_coord in signed Q16.8, plus is_last. Points are stored one per cycle. Points past
// MAX_POINTS are dropped and remembered in the overflowed flag of the result.
// A point with is_last set (stored if room remains) closes the set and starts Prim's
// method over squared distances. The block then accepts no input until the result
// has been handed to the output register.
// Passes: each of the n-1 tree passes sweeps all n points through a five-stage
// distance pipeline, but a pass cannot commit its edge before the square root of
// the previous edge has finished.
// Output channel (out_valid/out_ready): one transaction per set with total_length
// (unsigned Q24.8, saturating) and overflowed. The result sits in an output register,
// so a stalled receiver only stops the block once a second result is finished.
// Reset clears the point count, the drop flag and all handshake state.
module euclidean_mst_total_length #(
  parameter int MAX_POINTS = emst_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [emst_pkg::COORD_W-1:0] x_coord,
  input  logic signed [emst_pkg::COORD_W-1:0] y_coord,
  input  logic                                is_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [emst_pkg::TOT_W-1:0]          total_length,
  output logic                                overflowed
);
  import emst_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] idx, widx;

  // Sequencer: loading, pass control and the result handshake.
  emst_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .overflowed (overflowed),
    .cmd        (cmd),
    .sts        (sts),
    .idx        (idx),
    .widx       (widx)
  );

  // Point stores, distance pipeline, minimum search and square root.
  emst_dp #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .widx         (widx),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .sts          (sts),
    .total_length (total_length)
  );

endmodule
